### src/iopr_pkg.sv
// Shared types, codes and helpers for the IPv4 octet prefix router.
// No dependencies; used by the router core.
package iopr_pkg;

  // Command carried in the input tuser bit
  typedef enum logic {
    CMD_ADD    = 1'b0,
    CMD_LOOKUP = 1'b1
  } cmd_e;

  // Result status bit
  typedef enum logic {
    STATUS_OK   = 1'b0,
    STATUS_FULL = 1'b1
  } status_e;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  localparam int unsigned AddrBits   = 32;
  localparam int unsigned OctetBits  = 3;
  localparam int unsigned IfcBits    = 8;
  localparam int unsigned PlenBits   = 6;
  localparam logic [OctetBits-1:0] MaxOctets = 3'd4;

  // One stored route, as kept in the table memory
  typedef struct packed {
    logic [AddrBits-1:0]  prefix;
    logic [OctetBits-1:0] octets;
    logic [IfcBits-1:0]   ifc;
  } entry_t;

  localparam int unsigned EntryBits = $bits(entry_t);

  // Mask that keeps the leading octets of an address
  function automatic logic [AddrBits-1:0] octet_mask(input logic [OctetBits-1:0] oct);
    logic [AddrBits-1:0] m;
    case (oct)
      3'd1:    m = 32'hFF00_0000;
      3'd2:    m = 32'hFFFF_0000;
      3'd3:    m = 32'hFFFF_FF00;
      3'd4:    m = 32'hFFFF_FFFF;
      default: m = 32'h0000_0000;
    endcase
    return m;
  endfunction

  // Prefix length in bits to whole octets, saturated at four
  function automatic logic [OctetBits-1:0] plen_octets(input logic [PlenBits-1:0] plen);
    logic [OctetBits-1:0] o;
    o = plen[PlenBits-1:3];
    if (o > MaxOctets) begin
      o = MaxOctets;
    end
    return o;
  endfunction

endpackage

### src/iopr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module iopr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/ipv4_octet_prefix_router_core.sv
// Router core: whole-octet IPv4 route table with longest-prefix lookup; uses iopr_pkg, iopr_ram.
// Flow: a word is accepted while idle; the scan then reads one entry per cycle from the route
// memory and compares each stored route; the result is loaded once any held result is taken.
// A new word is taken only after the result of the last one is loaded into the output register.
// An add under eight bits skips the scan.
// Reset: asynchronous, active low; empties the table at once (fill count cleared).
module ipv4_octet_prefix_router_core #(
  parameter int unsigned ROUTE_ENTRIES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Command input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // address[31:0], prefix_length[37:32],
                                      // out_interface[45:38], zero[47:46]
  input  logic        s_axis_tuser,   // command[0]
  // Result output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // next_interface[7:0], status[8], zero[15:9]
  output logic        m_axis_tuser    // route_found[0]
);

  localparam int unsigned AW = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ROUTE_ENTRIES + 1);
  localparam logic [CW-1:0] FullCount = CW'(ROUTE_ENTRIES);

  // Control registers
  iopr_pkg::state_e state_q, state_d;
  logic [CW-1:0]    fill_q, fill_d;
  logic [CW-1:0]    issue_q, issue_d;
  logic             rd_vld_q, rd_vld_d;
  logic             out_valid_q, out_valid_d;

  // Payload registers
  iopr_pkg::cmd_e   cmd_q, cmd_d;
  logic [31:0]      key_q, key_d;
  logic [2:0]       oct_q, oct_d;
  logic [7:0]       ifc_q, ifc_d;
  logic [AW-1:0]    cmp_idx_q, cmp_idx_d;
  logic             hit_q, hit_d;
  logic [AW-1:0]    hit_idx_q, hit_idx_d;
  logic [2:0]       best_q, best_d;
  logic             found_q, found_d;
  logic [7:0]       nexti_q, nexti_d;
  logic             out_found_q, out_found_d;
  logic [7:0]       out_ifc_q, out_ifc_d;
  iopr_pkg::status_e out_status_q, out_status_d;

  // Memory port signals
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr;
  iopr_pkg::entry_t  ram_wdata, ram_rdata;

  logic in_fire, out_fire, rd_en, scan_done, finish_load;
  logic is_add, add_active, table_full;
  iopr_pkg::cmd_e   in_cmd;
  logic [2:0]       in_oct;

  assign in_cmd     = iopr_pkg::cmd_e'(s_axis_tuser);
  assign in_oct     = iopr_pkg::plen_octets(s_axis_tdata[37:32]);
  assign in_fire    = s_axis_tvalid && s_axis_tready;
  assign out_fire   = m_axis_tvalid && m_axis_tready;
  assign rd_en      = (state_q == iopr_pkg::ST_SCAN) && (issue_q < fill_q);
  assign scan_done  = !rd_en && !rd_vld_q;
  assign finish_load = (state_q == iopr_pkg::ST_FINISH) && (!out_valid_q || m_axis_tready);
  assign is_add     = (cmd_q == iopr_pkg::CMD_ADD);
  assign add_active = is_add && (oct_q != '0);
  assign table_full = (fill_q == FullCount);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      iopr_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_cmd == iopr_pkg::CMD_ADD && in_oct == '0) begin
            state_d = iopr_pkg::ST_FINISH;
          end else begin
            state_d = iopr_pkg::ST_SCAN;
          end
        end
      end
      iopr_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_d = iopr_pkg::ST_FINISH;
        end
      end
      iopr_pkg::ST_FINISH: begin
        if (finish_load) begin
          state_d = iopr_pkg::ST_IDLE;
        end
      end
      default: state_d = iopr_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: handshake and memory port
  always_comb begin
    s_axis_tready = (state_q == iopr_pkg::ST_IDLE);
    ram_re        = rd_en;
    ram_we        = finish_load && add_active && (hit_q || !table_full);
    ram_waddr     = hit_q ? hit_idx_q : fill_q[AW-1:0];
    ram_wdata.prefix = key_q;
    ram_wdata.octets = oct_q;
    ram_wdata.ifc    = ifc_q;
  end

  // Datapath next values
  always_comb begin
    logic [2:0] e_oct;
    logic       pfx_eq;
    fill_d       = fill_q;
    issue_d      = issue_q;
    rd_vld_d     = rd_en;
    cmp_idx_d    = issue_q[AW-1:0];
    out_valid_d  = out_valid_q;
    cmd_d        = cmd_q;
    key_d        = key_q;
    oct_d        = oct_q;
    ifc_d        = ifc_q;
    hit_d        = hit_q;
    hit_idx_d    = hit_idx_q;
    best_d       = best_q;
    found_d      = found_q;
    nexti_d      = nexti_q;
    out_found_d  = out_found_q;
    out_ifc_d    = out_ifc_q;
    out_status_d = out_status_q;
    e_oct        = ram_rdata.octets;
    pfx_eq       = 1'b0;

    // Capture the command word
    if (in_fire) begin
      cmd_d   = in_cmd;
      oct_d   = in_oct;
      ifc_d   = s_axis_tdata[45:38];
      key_d   = (in_cmd == iopr_pkg::CMD_ADD)
              ? (s_axis_tdata[31:0] & iopr_pkg::octet_mask(in_oct))
              : s_axis_tdata[31:0];
      issue_d = '0;
      hit_d   = 1'b0;
      best_d  = '0;
      found_d = 1'b0;
      nexti_d = '0;
    end

    // Step the read address through the stored routes
    if (rd_en) begin
      issue_d = issue_q + CW'(1);
    end

    // Compare the entry read in the previous cycle
    if (rd_vld_q) begin
      if (is_add) begin
        if (!hit_q && e_oct == oct_q && ram_rdata.prefix == key_q) begin
          hit_d     = 1'b1;
          hit_idx_d = cmp_idx_q;
        end
      end else begin
        pfx_eq = ((key_q & iopr_pkg::octet_mask(e_oct)) == ram_rdata.prefix);
        if (pfx_eq && e_oct > best_q) begin
          best_d  = e_oct;
          found_d = 1'b1;
          nexti_d = ram_rdata.ifc;
        end
      end
    end

    // Output register: a waiting result is held until taken
    if (out_fire) begin
      out_valid_d = 1'b0;
    end
    if (finish_load) begin
      out_valid_d  = 1'b1;
      out_found_d  = !is_add && found_q;
      out_ifc_d    = is_add ? 8'd0 : nexti_q;
      out_status_d = (add_active && !hit_q && table_full)
                   ? iopr_pkg::STATUS_FULL : iopr_pkg::STATUS_OK;
      if (add_active && !hit_q && !table_full) begin
        fill_d = fill_q + CW'(1);
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= iopr_pkg::ST_IDLE;
      fill_q      <= '0;
      issue_q     <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      issue_q     <= issue_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    key_q        <= key_d;
    oct_q        <= oct_d;
    ifc_q        <= ifc_d;
    cmp_idx_q    <= cmp_idx_d;
    hit_q        <= hit_d;
    hit_idx_q    <= hit_idx_d;
    best_q       <= best_d;
    found_q      <= found_d;
    nexti_q      <= nexti_d;
    out_found_q  <= out_found_d;
    out_ifc_q    <= out_ifc_d;
    out_status_q <= out_status_d;
  end

  // Route table memory
  iopr_ram #(
    .WIDTH (iopr_pkg::EntryBits),
    .DEPTH (ROUTE_ENTRIES)
  ) u_route_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (issue_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Result ports
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_found_q;
  assign m_axis_tdata  = {7'd0, out_status_q, out_ifc_q};

`ifndef SYNTHESIS
  // Fill count never runs past the table
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FullCount)
    else $error("route fill count exceeds table depth");

  // Table writes happen only when a result is loaded, never during a scan
  a_write_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == iopr_pkg::ST_FINISH) && !rd_en)
    else $error("route table written outside finish step");

  // Fill count only grows, one route at a time
  a_fill_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q != $past(fill_q)) |-> (fill_q == $past(fill_q) + CW'(1)))
    else $error("route fill count changed by more than one");

  // A refused add reports neither a match nor an interface, and only when full
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q == iopr_pkg::STATUS_FULL)
      |-> (!out_found_q && out_ifc_q == 8'd0 && fill_q == FullCount))
    else $error("full status reported with a match or free room");
`endif

endmodule
